// ===== src/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by rau_ctrl, rau_datapath and rational_arithmetic_unit.
`default_nettype none
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int PW    = 2 * WIDTH;
    localparam int KW    = $clog2(PW) + 1;

    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_MUL = 4'd2;
    localparam logic [3:0] FN_DIV = 4'd3;
    localparam logic [3:0] FN_LT  = 4'd4;
    localparam logic [3:0] FN_GT  = 4'd5;
    localparam logic [3:0] FN_EQ  = 4'd6;
    localparam logic [3:0] FN_NE  = 4'd7;
    localparam logic [3:0] FN_LE  = 4'd8;
    localparam logic [3:0] FN_GE  = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_A, S_MUL_B, S_MUL_C, S_MUL_D, S_COMBINE, S_CHECK,
        S_GCD, S_DIV_INIT_N, S_DIV_RUN_N, S_DIV_INIT_D, S_DIV_RUN_D, S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_MUL_A, CMD_MUL_B, CMD_MUL_C, CMD_MUL_D,
        CMD_COMBINE, CMD_GCD, CMD_DIV_INIT_N, CMD_DIV_STEP_N, CMD_DIV_INIT_D,
        CMD_DIV_STEP_D, CMD_WRITE
    } t_cmd;

    typedef struct packed {
        logic early;
        logic done_early;
        logic gcd_done;
        logic div_last;
        logic out_full;
    } t_status;

endpackage
`default_nettype wire

// ===== src/rau_ctrl.sv =====
// Controller state machine for the rational arithmetic unit.
// Depends on rau_pkg; drives commands into rau_datapath.
`default_nettype none
module rau_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  rau_pkg::t_status i_status,
    output logic             o_in_ready,
    output rau_pkg::t_cmd    o_cmd
);
    import rau_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (i_in_valid) n_state = S_MUL_A;
            S_MUL_A:      n_state = i_status.early ? S_FINISH : S_MUL_B;
            S_MUL_B:      n_state = S_MUL_C;
            S_MUL_C:      n_state = S_MUL_D;
            S_MUL_D:      n_state = S_COMBINE;
            S_COMBINE:    n_state = S_CHECK;
            S_CHECK:      n_state = i_status.done_early ? S_FINISH : S_GCD;
            S_GCD:        if (i_status.gcd_done) n_state = S_DIV_INIT_N;
            S_DIV_INIT_N: n_state = S_DIV_RUN_N;
            S_DIV_RUN_N:  if (i_status.div_last) n_state = S_DIV_INIT_D;
            S_DIV_INIT_D: n_state = S_DIV_RUN_D;
            S_DIV_RUN_D:  if (i_status.div_last) n_state = S_FINISH;
            S_FINISH:     if (!i_status.out_full) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_LOAD;
            end
            S_MUL_A:      o_cmd = CMD_MUL_A;
            S_MUL_B:      o_cmd = CMD_MUL_B;
            S_MUL_C:      o_cmd = CMD_MUL_C;
            S_MUL_D:      o_cmd = CMD_MUL_D;
            S_COMBINE:    o_cmd = CMD_COMBINE;
            S_CHECK:      o_cmd = CMD_NONE;
            S_GCD:        o_cmd = CMD_GCD;
            S_DIV_INIT_N: o_cmd = CMD_DIV_INIT_N;
            S_DIV_RUN_N:  o_cmd = CMD_DIV_STEP_N;
            S_DIV_INIT_D: o_cmd = CMD_DIV_INIT_D;
            S_DIV_RUN_D:  o_cmd = CMD_DIV_STEP_D;
            S_FINISH:     if (!i_status.out_full) o_cmd = CMD_WRITE;
            default:      o_cmd = CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/rau_datapath.sv =====
// Datapath: shared multiplier, sign-magnitude combine, binary gcd, restoring divider
// and output register. Depends on rau_pkg; driven by rau_ctrl.
`default_nettype none
module rau_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rau_pkg::t_cmd     i_cmd,
    input  wire  [3:0]        i_func,
    input  wire  [31:0]       i_a_num,
    input  wire  [31:0]       i_a_den,
    input  wire  [31:0]       i_b_num,
    input  wire  [31:0]       i_b_den,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output logic [31:0]       o_res_num,
    output logic [30:0]       o_res_den,
    output logic              o_truth,
    output logic [1:0]        o_stat,
    output rau_pkg::t_status  o_status
);
    import rau_pkg::*;

    localparam logic [PW-1:0] HALF = PW'(1) << (WIDTH - 1);

    logic [3:0]       r_func;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic [PW-1:0]    r_prod, r_t1, r_t2, r_num, r_den, r_x, r_y, r_q, r_rem, r_nm;
    logic             r_psign, r_s1, r_s2, r_nsign, r_dsign, r_truth;
    logic [KW-1:0]    r_k, r_cnt;
    logic             r_mvalid;
    logic [31:0]      r_onum;
    logic [30:0]      r_oden;
    logic             r_otruth;
    logic [1:0]       r_ostat;

    logic             an_n, ad_n, bn_n, bd_n;
    logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m, mul_x, mul_y;
    logic             mul_s, is_cmp, f_bad, f_zden, s2_eff;
    logic [PW-1:0]    sum_mag;
    logic             sum_sign;
    logic signed [PW:0] lhs, rhs;
    logic             cmp_t;
    logic [PW:0]      rem_sh, rem_sub;
    logic             q_bit;
    logic             res_neg, ovf;
    logic [PW-1:0]    nm_neg;
    logic [WIDTH-1:0] num_w;
    logic [31:0]      f_num;
    logic [30:0]      f_den;
    logic             f_truth;
    logic [1:0]       f_stat;

    always_comb begin
        an_n = r_an[WIDTH-1];
        ad_n = r_ad[WIDTH-1];
        bn_n = r_bn[WIDTH-1];
        bd_n = r_bd[WIDTH-1];
        an_m = an_n ? -r_an : r_an;
        ad_m = ad_n ? -r_ad : r_ad;
        bn_m = bn_n ? -r_bn : r_bn;
        bd_m = bd_n ? -r_bd : r_bd;
        f_bad  = r_func > FN_GE;
        f_zden = (r_ad == '0) || (r_bd == '0) || ((r_func == FN_DIV) && (r_bn == '0));
        is_cmp = r_func >= FN_LT;
    end

    always_comb begin
        mul_x = an_m;
        mul_y = bd_m;
        mul_s = an_n ^ bd_n;
        case (i_cmd)
            CMD_MUL_A: begin
                mul_x = an_m;
                mul_y = (r_func == FN_MUL) ? bn_m : bd_m;
                mul_s = an_n ^ ((r_func == FN_MUL) ? bn_n : bd_n);
            end
            CMD_MUL_B: begin
                mul_x = bn_m;
                mul_y = ad_m;
                mul_s = bn_n ^ ad_n;
            end
            default: begin
                mul_x = ad_m;
                mul_y = (r_func == FN_DIV) ? bn_m : bd_m;
                mul_s = ad_n ^ ((r_func == FN_DIV) ? bn_n : bd_n);
            end
        endcase
    end

    always_comb begin
        s2_eff = r_s2 ^ (r_func == FN_SUB);
        if (r_s1 == s2_eff) begin
            sum_mag  = r_t1 + r_t2;
            sum_sign = r_s1;
        end else if (r_t1 >= r_t2) begin
            sum_mag  = r_t1 - r_t2;
            sum_sign = r_s1;
        end else begin
            sum_mag  = r_t2 - r_t1;
            sum_sign = s2_eff;
        end
        lhs = (r_s1 ^ ad_n ^ bd_n) ? -$signed({1'b0, r_t1}) : $signed({1'b0, r_t1});
        rhs = (r_s2 ^ ad_n ^ bd_n) ? -$signed({1'b0, r_t2}) : $signed({1'b0, r_t2});
        case (r_func)
            FN_LT:   cmp_t = lhs < rhs;
            FN_GT:   cmp_t = lhs > rhs;
            FN_EQ:   cmp_t = lhs == rhs;
            FN_NE:   cmp_t = lhs != rhs;
            FN_LE:   cmp_t = lhs <= rhs;
            default: cmp_t = lhs >= rhs;
        endcase
    end

    always_comb begin
        rem_sh  = {r_rem, r_q[PW-1]};
        rem_sub = rem_sh - {1'b0, r_y};
        q_bit   = rem_sh >= {1'b0, r_y};
    end

    always_comb begin
        res_neg = r_nsign ^ r_dsign;
        ovf     = (r_q > HALF - PW'(1)) || (res_neg ? (r_nm > HALF) : (r_nm > HALF - PW'(1)));
        nm_neg  = res_neg ? -r_nm : r_nm;
        num_w   = nm_neg[WIDTH-1:0];
        f_num   = '0;
        f_den   = 31'd1;
        f_truth = 1'b0;
        f_stat  = ST_OK;
        if (f_bad) begin
            f_den = 31'd1;
        end else if (f_zden) begin
            f_den  = '0;
            f_stat = ST_ZDEN;
        end else if (is_cmp) begin
            f_truth = r_truth;
        end else if (r_num == '0) begin
            f_den = 31'd1;
        end else if (ovf) begin
            f_den  = '0;
            f_stat = ST_OVF;
        end else begin
            f_num = 32'($signed(num_w));
            f_den = 31'(r_q[WIDTH-2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_func <= i_func;
                r_an   <= i_a_num[WIDTH-1:0];
                r_ad   <= i_a_den[WIDTH-1:0];
                r_bn   <= i_b_num[WIDTH-1:0];
                r_bd   <= i_b_den[WIDTH-1:0];
            end
            CMD_MUL_A: begin
                r_prod  <= mul_x * mul_y;
                r_psign <= mul_s;
            end
            CMD_MUL_B: begin
                r_prod  <= mul_x * mul_y;
                r_psign <= mul_s;
                r_t1    <= r_prod;
                r_s1    <= r_psign;
            end
            CMD_MUL_C: begin
                r_prod  <= mul_x * mul_y;
                r_psign <= mul_s;
                r_t2    <= r_prod;
                r_s2    <= r_psign;
            end
            CMD_MUL_D: begin
                r_den   <= r_prod;
                r_dsign <= r_psign;
            end
            CMD_COMBINE: begin
                r_truth <= cmp_t;
                r_k     <= '0;
                r_y     <= r_den;
                if ((r_func == FN_ADD) || (r_func == FN_SUB)) begin
                    r_num   <= sum_mag;
                    r_nsign <= sum_sign;
                    r_x     <= sum_mag;
                end else begin
                    r_num   <= r_t1;
                    r_nsign <= r_s1;
                    r_x     <= r_t1;
                end
            end
            CMD_GCD: begin
                if (r_x != '0) begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + KW'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x >= r_y) begin
                        r_x <= (r_x - r_y) >> 1;
                    end else begin
                        r_y <= (r_y - r_x) >> 1;
                    end
                end
            end
            CMD_DIV_INIT_N: begin
                r_q   <= r_num >> r_k;
                r_rem <= '0;
                r_cnt <= '0;
            end
            CMD_DIV_INIT_D: begin
                r_nm  <= r_q;
                r_q   <= r_den >> r_k;
                r_rem <= '0;
                r_cnt <= '0;
            end
            CMD_DIV_STEP_N, CMD_DIV_STEP_D: begin
                r_rem <= q_bit ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
                r_q   <= {r_q[PW-2:0], q_bit};
                r_cnt <= r_cnt + KW'(1);
            end
            CMD_WRITE: begin
                r_onum   <= f_num;
                r_oden   <= f_den;
                r_otruth <= f_truth;
                r_ostat  <= f_stat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (i_cmd == CMD_WRITE) begin
            r_mvalid <= 1'b1;
        end else if (i_out_ready) begin
            r_mvalid <= 1'b0;
        end
    end

    assign o_out_valid         = r_mvalid;
    assign o_res_num           = r_onum;
    assign o_res_den           = r_oden;
    assign o_truth             = r_otruth;
    assign o_stat              = r_ostat;
    assign o_status.early      = f_bad || f_zden;
    assign o_status.done_early = is_cmp || (r_num == '0);
    assign o_status.gcd_done   = r_x == '0;
    assign o_status.div_last   = r_cnt == KW'(PW - 1);
    assign o_status.out_full   = r_mvalid && !i_out_ready;

endmodule
`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
// Unknown codes and zero denominators finish after the first multiply, compares and zero
// results after the check, others after the binary gcd loop plus two 64-step divisions.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: synchronous active-low i_rst_n clears the controller and output valid.
// Top level; depends on rau_pkg, rau_ctrl and rau_datapath.
`default_nettype none
module rational_arithmetic_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  wire  [3:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // res_num, res_den, truth
    output logic [1:0]   m_axis_tuser   // status
);
    import rau_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        truth;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    rau_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (s_axis_tuser),
        .i_a_num     (s_axis_tdata[31:0]),
        .i_a_den     (s_axis_tdata[63:32]),
        .i_b_num     (s_axis_tdata[95:64]),
        .i_b_den     (s_axis_tdata[127:96]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_res_num   (res_num),
        .o_res_den   (res_den),
        .o_truth     (truth),
        .o_stat      (m_axis_tuser),
        .o_status    (status)
    );

    assign m_axis_tdata = {truth, res_den, res_num};

endmodule
`default_nettype wire
